// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be true on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/bsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types and constants shared by the byte stuffed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 6;
    localparam int LEN_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int M_USED_W   = 2 + BYTE_W + LEN_W + BYTE_W + 1;

    localparam logic [BYTE_W-1:0] START_RESET      = 8'd2;
    localparam logic [BYTE_W-1:0] END_RESET        = 8'd3;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET     = 8'd16;
    localparam logic [BYTE_W-1:0] CHECK_INIT_RESET = 8'd0;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCOPE = 2'd1,
        PH_DATA  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_GOOD = 2'd1,
        EV_BAD  = 2'd2,
        EV_OVER = 2'd3
    } t_event;

    typedef enum logic {
        CMD_RECEIVE = 1'b0,
        CMD_READ    = 1'b1
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START      = 2'd0,
        REG_END        = 2'd1,
        REG_ESCAPE     = 2'd2,
        REG_CHECK_INIT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] check_init;
    } t_cfg;

    typedef struct packed {
        t_event            frame_event;
        logic [BYTE_W-1:0] frame_scope;
        logic [LEN_W-1:0]  frame_length;
        logic              in_frame;
    } t_rx_status;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] data;
    } t_buf_wr;

endpackage

`default_nettype wire

// ----- sv/bsfr_rx_core.sv -----
// ----------------------------------------------------------------------------
// bsfr_rx_core
// Deframing state: escape handling, XOR checksum, length and overflow.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsfr_rx_core
    import bsfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cfg                            i_cfg,
    input  wire logic                            i_take,
    input  wire logic [BYTE_W-1:0]               i_byte,
    output t_rx_status                           o_status,
    output t_buf_wr                              o_wr,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      o_wr_addr
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 2);
    localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_P1 = CW'(BUFFER_DEPTH + 1);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_check, n_check;
    logic              r_esc, n_esc;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_scope, n_scope;
    logic              r_ovf, n_ovf;

    t_event w_event;
    logic   w_restart;
    logic   w_is_start, w_is_end, w_is_esc;

    assign w_is_start = (i_byte == i_cfg.start_byte);
    assign w_is_end   = (i_byte == i_cfg.end_byte);
    assign w_is_esc   = (i_byte == i_cfg.escape_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_check <= '0;
            r_esc   <= 1'b0;
            r_count <= '0;
            r_scope <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_check <= n_check;
            r_esc   <= n_esc;
            r_count <= n_count;
            r_scope <= n_scope;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_check   = r_check;
        n_esc     = r_esc;
        n_count   = r_count;
        n_scope   = r_scope;
        n_ovf     = r_ovf;
        w_event   = EV_NONE;
        w_restart = 1'b0;
        o_wr.en   = 1'b0;
        o_wr.data = i_byte;
        if (i_take) begin
            unique case (r_phase) inside
                PH_SCOPE, PH_DATA: begin
                    if (r_esc || !(w_is_start || w_is_end || w_is_esc)) begin
                        n_esc   = 1'b0;
                        n_check = r_check ^ i_byte;
                        if (r_phase == PH_SCOPE) begin
                            n_scope = i_byte;
                            n_phase = PH_DATA;
                        end else if (r_count >= DEPTH_P1) begin
                            n_ovf   = 1'b1;
                            w_event = EV_OVER;
                        end else begin
                            o_wr.en = (r_count < DEPTH_C);
                            n_count = r_count + 1'b1;
                        end
                    end else if (w_is_start) begin
                        w_restart = 1'b1;
                    end else if (w_is_esc) begin
                        n_esc = 1'b1;
                    end else begin
                        // end of frame: drop the checksum byte from the length
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                        n_phase = PH_IDLE;
                        if (r_ovf) begin
                            w_event = EV_OVER;
                        end else if (r_check == '0) begin
                            w_event = EV_GOOD;
                        end else begin
                            w_event = EV_BAD;
                        end
                    end
                end
                default: begin
                    w_restart = w_is_start;
                end
            endcase
            if (w_restart) begin
                n_phase = PH_SCOPE;
                n_check = i_cfg.check_init;
                n_esc   = 1'b0;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    assign o_wr_addr = r_count[AW-1:0];

    assign o_status.frame_event  = w_event;
    assign o_status.frame_scope  = n_scope;
    assign o_status.frame_length = LEN_W'(n_count);
    assign o_status.in_frame     = (n_phase == PH_SCOPE) || (n_phase == PH_DATA);

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_P1,
        "byte count past full payload plus checksum")
    `ASSERT_CLK(a_wr_in_data, i_clk, i_rst_n,
        o_wr.en |-> ((r_phase == PH_DATA) && (r_count < DEPTH_C)),
        "buffer write outside data phase or range")
    `ASSERT_NEVER(a_event_needs_take, i_clk, i_rst_n,
        !i_take && (w_event != EV_NONE),
        "frame event without a received byte")

endmodule

`default_nettype wire

// ----- sv/byte_stuffed_frame_receiver.sv -----
// A transfer accepted into the input register passes through the core into the
// result register, which drives the result stream.
// Throughput: one transfer per cycle; a held result lets one more transfer in,
// then the input stalls. The payload buffer has one write and one read port.
// Reset (i_rst_n low, synchronous) clears the pipeline, receive state and
// loads the default configuration; buffer contents are not cleared.
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Byte stuffed frame receiver with XOR checksum and payload buffer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module byte_stuffed_frame_receiver
    import bsfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [BYTE_W-1:0]     i_cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // line_byte[7:0], read_index[13:8]
    input  wire logic                  s_axis_tuser,  // command[0]
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // frame_event[1:0], frame_scope[9:2], frame_length[16:10], read_data[24:17],
    // in_frame[25]
    output logic [M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    t_cfg r_cfg;

    logic              r_in_valid;
    t_cmd              r_in_cmd;
    logic [BYTE_W-1:0] r_in_byte;
    logic [IDX_W-1:0]  r_in_idx;

    logic              r_out_valid;
    t_rx_status        r_out_status;
    logic              r_out_rd_ok;
    logic [BYTE_W-1:0] r_mem_q;

    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];

    logic              w_advance;
    logic              w_fire;
    logic              w_rd_ok;
    logic [AW-1:0]     w_rd_addr;
    t_rx_status        w_status;
    t_buf_wr           w_wr;
    logic [AW-1:0]     w_wr_addr;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= START_RESET;
            r_cfg.end_byte    <= END_RESET;
            r_cfg.escape_byte <= ESCAPE_RESET;
            r_cfg.check_init  <= CHECK_INIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_START:      r_cfg.start_byte  <= i_cfg_wdata;
                REG_END:        r_cfg.end_byte    <= i_cfg_wdata;
                REG_ESCAPE:     r_cfg.escape_byte <= i_cfg_wdata;
                REG_CHECK_INIT: r_cfg.check_init  <= i_cfg_wdata;
                default:        r_cfg             <= r_cfg;
            endcase
        end
    end

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= t_cmd'(s_axis_tuser);
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
            r_in_idx  <= s_axis_tdata[BYTE_W +: IDX_W];
        end
    end

    bsfr_rx_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_take    (w_fire && (r_in_cmd == CMD_RECEIVE)),
        .i_byte    (r_in_byte),
        .o_status  (w_status),
        .o_wr      (w_wr),
        .o_wr_addr (w_wr_addr)
    );

    assign w_rd_ok   = (r_in_cmd == CMD_READ) && (int'(r_in_idx) < BUFFER_DEPTH);
    assign w_rd_addr = AW'(r_in_idx);

    // payload buffer
    always_ff @(posedge i_clk) begin
        if (w_wr.en) begin
            r_mem[w_wr_addr] <= w_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= w_status;
            r_out_rd_ok  <= w_rd_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {(M_TDATA_W - M_USED_W){1'b0}},
        r_out_status.in_frame,
        (r_out_rd_ok ? r_mem_q : {BYTE_W{1'b0}}),
        r_out_status.frame_length,
        r_out_status.frame_scope,
        r_out_status.frame_event
    };

    `ASSERT_CLK(a_wr_on_fire, i_clk, i_rst_n, w_wr.en |-> w_fire,
        "buffer written without a transfer in the pipeline")
    `ASSERT_CLK(a_read_no_event, i_clk, i_rst_n,
        (w_fire && (r_in_cmd == CMD_READ)) |=>
            (r_out_valid && (r_out_status.frame_event == EV_NONE)),
        "read command produced a frame event")
    `ASSERT_NEVER(a_stall_only_full, i_clk, i_rst_n,
        !s_axis_tready && !(r_in_valid && r_out_valid),
        "input stalled while a pipeline stage is free")

endmodule

`default_nettype wire
